>>> sv/bpu_pkg.sv
package bpu_pkg;

    localparam int MAX_SOURCE_WIDTH  = 64;
    localparam int MAX_SOURCE_HEIGHT = 64;
    localparam int MAX_TARGET_DIM    = 4096;
    localparam int CHANNELS          = 4;

    localparam int COL_W   = $clog2(MAX_SOURCE_WIDTH);
    localparam int ROW_W   = $clog2(MAX_SOURCE_HEIGHT);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int DEPTH   = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int SW_W    = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int SH_W    = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int TD_W    = $clog2(MAX_TARGET_DIM + 1);
    localparam int COORD_W = 12;
    localparam int PIX_W   = 32;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 3;

    localparam int DIV_STEPS = 28;
    localparam int NUM_W     = DIV_STEPS;
    localparam int QUO_W     = DIV_STEPS;

    typedef enum logic [IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_TARGET_WIDTH  = 3'd2,
        REG_TARGET_HEIGHT = 3'd3,
        REG_FILTER_MODE   = 3'd4
    } reg_index_t;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef enum logic {
        MODE_NEAREST  = 1'b0,
        MODE_BILINEAR = 1'b1
    } mode_t;

    typedef struct packed {
        logic             valid;
        logic             err;
        logic             mode;
        logic [COL_W-1:0] x0;
        logic [COL_W-1:0] x1;
        logic [ROW_W-1:0] y0;
        logic [ROW_W-1:0] y1;
        logic [8:0]       tx;
        logic [8:0]       ty;
    } tap_ctl_t;

endpackage

>>> sv/bpu_ram.sv
module bpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/bpu_div.sv
module bpu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [bpu_pkg::NUM_W-1:0]   num,
    input  logic [bpu_pkg::TD_W-1:0]    den,
    output logic [bpu_pkg::QUO_W-1:0]   quo,
    output logic [bpu_pkg::TD_W-1:0]    rem
);

    localparam int N = bpu_pkg::DIV_STEPS;

    logic [bpu_pkg::NUM_W-1:0] num_reg [N+1];
    logic [bpu_pkg::TD_W:0]    rem_reg [N+1];
    logic [bpu_pkg::TD_W-1:0]  den_reg [N+1];
    logic [bpu_pkg::QUO_W-1:0] quo_reg [N+1];

    always_comb
    begin
        num_reg[0] = num;
        rem_reg[0] = '0;
        den_reg[0] = den;
        quo_reg[0] = '0;
    end

    for (genvar s = 0; s < N; s++)
    begin : g_step
        logic [bpu_pkg::TD_W:0] trial;
        logic [bpu_pkg::TD_W:0] diff;
        assign trial = {rem_reg[s][bpu_pkg::TD_W-1:0], num_reg[s][bpu_pkg::NUM_W-1]};
        assign diff  = trial - {1'b0, den_reg[s]};
        always_ff @(posedge clk)
        begin
            num_reg[s+1] <= num_reg[s] << 1;
            den_reg[s+1] <= den_reg[s];
            if (!diff[bpu_pkg::TD_W])
            begin
                rem_reg[s+1] <= diff;
                quo_reg[s+1] <= {quo_reg[s][bpu_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= trial;
                quo_reg[s+1] <= {quo_reg[s][bpu_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    assign quo = quo_reg[N];
    assign rem = rem_reg[N][bpu_pkg::TD_W-1:0];

    logic unused;
    assign unused = in_valid & rst_n;

endmodule

>>> sv/bpu_lane.sv
module bpu_lane (
    input  logic       clk,
    input  logic [8:0] tx,
    input  logic [8:0] ty,
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  logic [7:0] d,
    input  logic [7:0] e,
    output logic [7:0] v
);

    logic [16:0] top_reg, bot_reg;
    logic [8:0]  ty_reg;
    logic [25:0] acc_reg;
    logic [25:0] sum;

    always_ff @(posedge clk)
    begin
        top_reg <= 17'((9'd256 - tx) * a) + 17'(tx * b);
        bot_reg <= 17'((9'd256 - tx) * d) + 17'(tx * e);
        ty_reg  <= ty;
        acc_reg <= 26'((9'd256 - ty_reg) * top_reg) + 26'(ty_reg * bot_reg);
    end

    assign sum = acc_reg + 26'd32768;
    assign v   = (sum[25:16] > 10'd255) ? 8'hFF : sum[23:16];

endmodule

>>> sv/bilinear_pixel_upscaler_unit.sv
// Bilinear/nearest pixel upscaler. Load transactions (func 0) write one pixel of the
// 64x64 source store and return nothing; sample transactions (func 1) return one scaled
// pixel. One transaction is accepted per cycle; a sample's result passes through the pipelined
// restoring dividers (28 stages) that map the coordinate, the tap register, the four banked
// source reads and the two-stage per-channel interpolation. Loads are delayed by a register
// chain before they reach the store so that every sample reads the image as it stood when the
// sample was accepted. Input stalls only when 64 samples are outstanding in the pipeline and
// result FIFO. Write configuration only while idle.
module bilinear_pixel_upscaler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // coord_x[11:0], coord_y[23:12], pixel_in[55:24]
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // pixel_out
    output logic        m_axis_tuser,  // range_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int LAT = bpu_pkg::DIV_STEPS + 6;
    localparam int FIFO_D = 64;
    localparam int FP_W = $clog2(FIFO_D);

    logic [6:0]  sw_cfg_reg, sh_cfg_reg;
    logic [12:0] tw_cfg_reg, th_cfg_reg;
    logic        mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_cfg_reg <= 7'd64;
            sh_cfg_reg <= 7'd64;
            tw_cfg_reg <= 13'd64;
            th_cfg_reg <= 13'd64;
            mode_reg   <= bpu_pkg::MODE_BILINEAR;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bpu_pkg::REG_SOURCE_WIDTH:  sw_cfg_reg <= cfg_data[6:0];
                bpu_pkg::REG_SOURCE_HEIGHT: sh_cfg_reg <= cfg_data[6:0];
                bpu_pkg::REG_TARGET_WIDTH:  tw_cfg_reg <= cfg_data;
                bpu_pkg::REG_TARGET_HEIGHT: th_cfg_reg <= cfg_data;
                bpu_pkg::REG_FILTER_MODE:   mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [bpu_pkg::SW_W-1:0] sw;
    logic [bpu_pkg::SH_W-1:0] sh;
    logic [bpu_pkg::TD_W-1:0] dw, dh;
    assign sw = (sw_cfg_reg == 7'd0) ? 7'd1 : (sw_cfg_reg > 7'd64) ? 7'd64 : sw_cfg_reg;
    assign sh = (sh_cfg_reg == 7'd0) ? 7'd1 : (sh_cfg_reg > 7'd64) ? 7'd64 : sh_cfg_reg;
    assign dw = (tw_cfg_reg == 13'd0) ? 13'd1 : (tw_cfg_reg > 13'd4096) ? 13'd4096 : tw_cfg_reg;
    assign dh = (th_cfg_reg == 13'd0) ? 13'd1 : (th_cfg_reg > 13'd4096) ? 13'd4096 : th_cfg_reg;

    // output fifo with credit count
    logic [FP_W:0] credit_reg;
    logic [FP_W:0] fifo_cnt_reg;
    logic [FP_W-1:0] wp_reg, rp_reg, rp_next;
    logic in_fire, out_fire, res_valid;
    logic [32:0] res_data, fifo_rdata, byp_data_reg, out_data;
    logic byp_valid_reg;
    logic [LAT-1:0] pend_reg;

    assign s_axis_tready = (credit_reg != '0);
    assign in_fire = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign out_fire = m_axis_tvalid & m_axis_tready;
    assign rp_next = rp_reg + FP_W'(out_fire);
    assign out_data = byp_valid_reg ? byp_data_reg : fifo_rdata;
    assign {m_axis_tuser, m_axis_tdata} = out_data;

    logic smp;
    assign smp = in_fire & (s_axis_tuser == bpu_pkg::FUNC_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg    <= (FP_W+1)'(FIFO_D);
            fifo_cnt_reg  <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg    <= credit_reg - (FP_W+1)'(smp) + (FP_W+1)'(out_fire);
            fifo_cnt_reg  <= fifo_cnt_reg + (FP_W+1)'(res_valid) - (FP_W+1)'(out_fire);
            byp_valid_reg <= res_valid && (rp_next == wp_reg);
            if (res_valid)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            byp_data_reg <= res_data;
        end
    end

    bpu_ram #(.WIDTH(33), .DEPTH(FIFO_D)) u_fifo (.clk(clk), .we(res_valid), .waddr(wp_reg),
        .wdata(res_data), .raddr(rp_next), .rdata(fifo_rdata));

    // coordinate mapping
    logic [11:0] cx, cy;
    assign cx = s_axis_tdata[11:0];
    assign cy = s_axis_tdata[23:12];

    function automatic logic [27:0] NUM_PAD(input logic [26:0] v);
        NUM_PAD = {v[20:0], 7'd0};
    endfunction

    logic [bpu_pkg::NUM_W-1:0] nx_num, ny_num;
    logic nx_neg, ny_neg;
    logic [26:0] ax, ay;
    always_comb
    begin
        logic [26:0] px, py;
        px = 27'(({12'd0, cx, 1'b1}) * sw);
        py = 27'(({12'd0, cy, 1'b1}) * sh);
        nx_neg = (mode_reg == bpu_pkg::MODE_BILINEAR) && (px < 27'(dw));
        ny_neg = (mode_reg == bpu_pkg::MODE_BILINEAR) && (py < 27'(dh));
        ax = nx_neg ? 27'(dw) - px : px - 27'(dw);
        ay = ny_neg ? 27'(dh) - py : py - 27'(dh);
        if (mode_reg == bpu_pkg::MODE_BILINEAR)
        begin
            nx_num = nx_neg ? (NUM_PAD(ax) + 28'(dw) - 28'd1) : NUM_PAD(ax);
            ny_num = ny_neg ? (NUM_PAD(ay) + 28'(dh) - 28'd1) : NUM_PAD(ay);
        end
        else
        begin
            nx_num = 28'(cx * sw);
            ny_num = 28'(cy * sh);
        end
    end

    logic [bpu_pkg::QUO_W-1:0] qx, qy;
    logic [bpu_pkg::TD_W-1:0]  rx_unused, ry_unused;

    bpu_div u_divx (.clk(clk), .rst_n(rst_n), .in_valid(smp), .num(nx_num), .den(dw),
                    .quo(qx), .rem(rx_unused));
    bpu_div u_divy (.clk(clk), .rst_n(rst_n), .in_valid(smp), .num(ny_num), .den(dh),
                    .quo(qy), .rem(ry_unused));

    // side pipeline carrying control alongside the divider
    localparam int DS = bpu_pkg::DIV_STEPS;
    logic sv_reg [DS];
    logic serr_reg [DS], smode_reg [DS], snx_reg [DS], sny_reg [DS];
    logic [bpu_pkg::SW_W-1:0] ssw_reg [DS];
    logic [bpu_pkg::SH_W-1:0] ssh_reg [DS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DS; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sv_reg[0] <= smp;
            for (int i = 1; i < DS; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        serr_reg[0]  <= (13'(cx) >= dw) || (13'(cy) >= dh);
        smode_reg[0] <= mode_reg;
        snx_reg[0]   <= nx_neg;
        sny_reg[0]   <= ny_neg;
        ssw_reg[0]   <= sw;
        ssh_reg[0]   <= sh;
        for (int i = 1; i < DS; i++)
        begin
            serr_reg[i]  <= serr_reg[i-1];
            smode_reg[i] <= smode_reg[i-1];
            snx_reg[i]   <= snx_reg[i-1];
            sny_reg[i]   <= sny_reg[i-1];
            ssw_reg[i]   <= ssw_reg[i-1];
            ssh_reg[i]   <= ssh_reg[i-1];
        end
    end

    // index and weight
    bpu_pkg::tap_ctl_t tap_next, tap_reg;
    always_comb
    begin
        logic signed [29:0] px, py, ix, iy, xc, yc, wx, wy;
        px = snx_reg[DS-1] ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
        py = sny_reg[DS-1] ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
        ix = px >>> 8;
        iy = py >>> 8;
        xc = (ix < 0) ? 30'sd0 : (ix > 30'(ssw_reg[DS-1]) - 1) ? 30'(ssw_reg[DS-1]) - 1 : ix;
        yc = (iy < 0) ? 30'sd0 : (iy > 30'(ssh_reg[DS-1]) - 1) ? 30'(ssh_reg[DS-1]) - 1 : iy;
        wx = px - (xc <<< 8);
        wy = py - (yc <<< 8);
        tap_next.valid = sv_reg[DS-1];
        tap_next.err   = serr_reg[DS-1];
        tap_next.mode  = smode_reg[DS-1];
        if (smode_reg[DS-1] == bpu_pkg::MODE_BILINEAR)
        begin
            tap_next.x0 = xc[bpu_pkg::COL_W-1:0];
            tap_next.y0 = yc[bpu_pkg::ROW_W-1:0];
            tap_next.x1 = (xc + 1 > 30'(ssw_reg[DS-1]) - 1) ? xc[bpu_pkg::COL_W-1:0]
                          : bpu_pkg::COL_W'(xc + 1);
            tap_next.y1 = (yc + 1 > 30'(ssh_reg[DS-1]) - 1) ? yc[bpu_pkg::ROW_W-1:0]
                          : bpu_pkg::ROW_W'(yc + 1);
            tap_next.tx = (wx < 0) ? 9'd0 : (wx > 256) ? 9'd256 : wx[8:0];
            tap_next.ty = (wy < 0) ? 9'd0 : (wy > 256) ? 9'd256 : wy[8:0];
        end
        else
        begin
            tap_next.x0 = qx[bpu_pkg::COL_W-1:0];
            tap_next.y0 = qy[bpu_pkg::ROW_W-1:0];
            tap_next.x1 = qx[bpu_pkg::COL_W-1:0];
            tap_next.y1 = qy[bpu_pkg::ROW_W-1:0];
            tap_next.tx = 9'd0;
            tap_next.ty = 9'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

    // four banked copies of the source store
    localparam int LD_D = DS + 1;
    logic ld;
    logic [bpu_pkg::ADDR_W-1:0] waddr;
    assign ld = in_fire && (s_axis_tuser == bpu_pkg::FUNC_LOAD)
                && (cx < 12'd64) && (cy < 12'd64);
    assign waddr = {cy[bpu_pkg::ROW_W-1:0], cx[bpu_pkg::COL_W-1:0]};

    // delay loads to the read slot of later samples
    logic                       ld_v_reg [LD_D];
    logic [bpu_pkg::ADDR_W-1:0] ld_a_reg [LD_D];
    logic [31:0]                ld_d_reg [LD_D];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LD_D; i++)
            begin
                ld_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            ld_v_reg[0] <= ld;
            for (int i = 1; i < LD_D; i++)
            begin
                ld_v_reg[i] <= ld_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ld_a_reg[0] <= waddr;
        ld_d_reg[0] <= s_axis_tdata[55:24];
        for (int i = 1; i < LD_D; i++)
        begin
            ld_a_reg[i] <= ld_a_reg[i-1];
            ld_d_reg[i] <= ld_d_reg[i-1];
        end
    end

    logic                       st_we;
    logic [bpu_pkg::ADDR_W-1:0] st_waddr;
    logic [31:0]                st_wdata;
    assign st_we    = ld_v_reg[LD_D-1];
    assign st_waddr = ld_a_reg[LD_D-1];
    assign st_wdata = ld_d_reg[LD_D-1];

    logic [31:0] p00, p10, p01, p11;
    bpu_ram #(.WIDTH(32), .DEPTH(bpu_pkg::DEPTH)) u_b00 (.clk(clk), .we(st_we),
        .waddr(st_waddr), .wdata(st_wdata), .raddr({tap_reg.y0, tap_reg.x0}), .rdata(p00));
    bpu_ram #(.WIDTH(32), .DEPTH(bpu_pkg::DEPTH)) u_b10 (.clk(clk), .we(st_we),
        .waddr(st_waddr), .wdata(st_wdata), .raddr({tap_reg.y0, tap_reg.x1}), .rdata(p10));
    bpu_ram #(.WIDTH(32), .DEPTH(bpu_pkg::DEPTH)) u_b01 (.clk(clk), .we(st_we),
        .waddr(st_waddr), .wdata(st_wdata), .raddr({tap_reg.y1, tap_reg.x0}), .rdata(p01));
    bpu_ram #(.WIDTH(32), .DEPTH(bpu_pkg::DEPTH)) u_b11 (.clk(clk), .we(st_we),
        .waddr(st_waddr), .wdata(st_wdata), .raddr({tap_reg.y1, tap_reg.x1}), .rdata(p11));

    bpu_pkg::tap_ctl_t rd_reg, l1_reg, l2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            l1_reg <= '0;
            l2_reg <= '0;
        end
        else
        begin
            rd_reg <= tap_reg;
            l1_reg <= rd_reg;
            l2_reg <= l1_reg;
        end
    end

    logic [31:0] blend;
    for (genvar c = 0; c < bpu_pkg::CHANNELS; c++)
    begin : g_lane
        bpu_lane u_lane (.clk(clk), .tx(rd_reg.tx), .ty(rd_reg.ty),
            .a(p00[8*c+:8]), .b(p10[8*c+:8]), .d(p01[8*c+:8]), .e(p11[8*c+:8]),
            .v(blend[8*c+:8]));
    end

    assign res_valid = l2_reg.valid;
    assign res_data  = l2_reg.err ? {1'b1, 32'd0} : {1'b0, blend};

    logic unused_tail;
    assign unused_tail = (^s_axis_tdata[63:56]) ^ (^rx_unused) ^ (^ry_unused) ^ pend_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= {pend_reg[LAT-2:0], smp};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= (FP_W+1)'(FIFO_D))
        else $error("result fifo overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && l2_reg.err |-> res_data[31:0] == 32'd0)
        else $error("range error with nonzero pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg.valid |=> rd_reg.valid)
        else $error("lost sample in read stage");

endmodule

>>> bench/bilinear_pixel_upscaler_checker.sv
module bilinear_pixel_upscaler_checker
    import bpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] pixel;
        logic        range_err;
    } scaled_t;

    logic [31:0] image_store [DEPTH];
    logic [6:0]  src_w;
    logic [6:0]  src_h;
    logic [12:0] dst_w;
    logic [12:0] dst_h;
    logic        mode;
    scaled_t     expected_pixels [$];

    assign pending = expected_pixels.size();

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint map_pos(longint d, longint s, longint dd);
        longint n;
        n = ((2 * d + 1) * s - dd) * 128;
        if (n >= 0)
            return n / dd;
        return -((-n + dd - 1) / dd);
    endfunction

    function automatic longint whole_part(longint p);
        if (p >= 0)
            return p / 256;
        return -((-p + 255) / 256);
    endfunction

    function automatic logic [31:0] texel(longint c, longint r);
        return image_store[r * MAX_SOURCE_WIDTH + c];
    endfunction

    function automatic scaled_t scale_pixel(longint cx, longint cy);
        scaled_t res;
        longint sw, sh, dw, dh, px, py, x0, y0, x1, y1, tx, ty;
        longint a, b, d, e, top, bot, v;
        logic [31:0] p00, p10, p01, p11;
        sw = clampv(src_w, 1, MAX_SOURCE_WIDTH);
        sh = clampv(src_h, 1, MAX_SOURCE_HEIGHT);
        dw = clampv(dst_w, 1, MAX_TARGET_DIM);
        dh = clampv(dst_h, 1, MAX_TARGET_DIM);
        res = '0;
        if (cx >= dw || cy >= dh)
        begin
            res.range_err = 1'b1;
            return res;
        end
        if (mode == MODE_NEAREST)
        begin
            res.pixel = texel((cx * sw) / dw, (cy * sh) / dh);
            return res;
        end
        px = map_pos(cx, sw, dw);
        py = map_pos(cy, sh, dh);
        x0 = clampv(whole_part(px), 0, sw - 1);
        y0 = clampv(whole_part(py), 0, sh - 1);
        x1 = clampv(x0 + 1, 0, sw - 1);
        y1 = clampv(y0 + 1, 0, sh - 1);
        tx = clampv(px - x0 * 256, 0, 256);
        ty = clampv(py - y0 * 256, 0, 256);
        p00 = texel(x0, y0);
        p10 = texel(x1, y0);
        p01 = texel(x0, y1);
        p11 = texel(x1, y1);
        for (int c = 0; c < CHANNELS; c++)
        begin
            a = p00[8*c +: 8];
            b = p10[8*c +: 8];
            d = p01[8*c +: 8];
            e = p11[8*c +: 8];
            top = (256 - tx) * a + tx * b;
            bot = (256 - tx) * d + tx * e;
            v = ((256 - ty) * top + ty * bot + 32768) >> 16;
            if (v > 255)
                v = 255;
            res.pixel[8*c +: 8] = v[7:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scaled_t want;
        if (!rst_n)
        begin
            src_w <= 7'd64;
            src_h <= 7'd64;
            dst_w <= 13'd64;
            dst_h <= 13'd64;
            mode <= MODE_BILINEAR;
            expected_pixels.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  src_w <= cfg_data[6:0];
                    REG_SOURCE_HEIGHT: src_h <= cfg_data[6:0];
                    REG_TARGET_WIDTH:  dst_w <= cfg_data;
                    REG_TARGET_HEIGHT: dst_h <= cfg_data;
                    REG_FILTER_MODE:   mode <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == FUNC_LOAD)
                begin
                    if (s_axis_tdata[11:0] < MAX_SOURCE_WIDTH
                        && s_axis_tdata[23:12] < MAX_SOURCE_HEIGHT)
                        image_store[s_axis_tdata[23:12] * MAX_SOURCE_WIDTH
                                    + s_axis_tdata[11:0]] = s_axis_tdata[55:24];
                end
                else
                    expected_pixels.push_back(scale_pixel(s_axis_tdata[11:0],
                                                          s_axis_tdata[23:12]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: pixel %h err %b",
                                 m_axis_tdata, m_axis_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.pixel !== m_axis_tdata || want.range_err !== m_axis_tuser)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: pixel exp %h got %h, err exp %b got %b",
                                     want.pixel, m_axis_tdata, want.range_err,
                                     m_axis_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb_bilinear_pixel_upscaler_unit.sv
module tb_bilinear_pixel_upscaler_unit;
    import bpu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int FILL_DIM = 8;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic [6:0]  cur_sw;
    logic [6:0]  cur_sh;
    logic [12:0] cur_dw;
    logic [12:0] cur_dh;

    bilinear_pixel_upscaler_unit uut (.*);

    bilinear_pixel_upscaler_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("** bilinear_pixel_upscaler_unit: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  cur_sw = value[6:0];
            REG_SOURCE_HEIGHT: cur_sh = value[6:0];
            REG_TARGET_WIDTH:  cur_dw = value;
            REG_TARGET_HEIGHT: cur_dh = value;
            default: ;
        endcase
    endtask

    task automatic send(func_t f, logic [11:0] x, logic [11:0] y, logic [31:0] pix);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f;
        s_axis_tdata <= {8'h00, pix, y, x};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic fill_image();
        for (int r = 0; r < FILL_DIM; r++)
            for (int c = 0; c < FILL_DIM; c++)
                send(FUNC_LOAD, 12'(c), 12'(r), $urandom());
    endtask

    task automatic sample_random(int count);
        logic [11:0] x;
        logic [11:0] y;
        int dw;
        int dh;
        dw = cur_dw == 0 ? 1 : (cur_dw > MAX_TARGET_DIM ? MAX_TARGET_DIM : cur_dw);
        dh = cur_dh == 0 ? 1 : (cur_dh > MAX_TARGET_DIM ? MAX_TARGET_DIM : cur_dh);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                x = $urandom();
                y = $urandom();
            end
            else
            begin
                x = $urandom_range(0, dw - 1);
                y = $urandom_range(0, dh - 1);
            end
            if ($urandom_range(0, 5) == 0)
                send(FUNC_LOAD, $urandom_range(0, 70), $urandom_range(0, 70), $urandom());
            else
                send(FUNC_SAMPLE, x, y, $urandom());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_LOAD;
        cfg_valid = 1'b0;
        cfg_index = REG_SOURCE_WIDTH;
        cfg_data = '0;
        cur_sw = 7'd64;
        cur_sh = 7'd64;
        cur_dw = 13'd64;
        cur_dh = 13'd64;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_SOURCE_WIDTH, 13'(FILL_DIM));
        write_reg(REG_SOURCE_HEIGHT, 13'(FILL_DIM));
        fill_image();
        send(FUNC_LOAD, 12'hFFF, 12'd3, 32'hFFFFFFFF);
        send(FUNC_LOAD, 12'd2, 12'hFFF, 32'h0);
        send(FUNC_LOAD, 12'd63, 12'd63, 32'hFFFFFFFF);
        send(FUNC_LOAD, 12'd63, 12'd0, 32'hFFFFFFFF);
        send(FUNC_LOAD, 12'd0, 12'd0, 32'h00000000);
        send(FUNC_SAMPLE, 12'd0, 12'd0, 32'hFFFFFFFF);
        send(FUNC_SAMPLE, 12'd63, 12'd63, 32'h0);
        send(FUNC_SAMPLE, 12'd64, 12'd0, 32'h0);
        send(FUNC_SAMPLE, 12'd0, 12'd64, 32'h0);
        send(FUNC_SAMPLE, 12'hFFF, 12'hFFF, 32'h0);
        send(FUNC_SAMPLE, 12'hAAA, 12'h555, 32'h0);
        drain();
        write_reg(REG_TARGET_WIDTH, 13'd4096);
        write_reg(REG_TARGET_HEIGHT, 13'd4096);
        write_reg(REG_SOURCE_WIDTH, 7'd1);
        write_reg(REG_SOURCE_HEIGHT, 7'd1);
        send(FUNC_SAMPLE, 12'd0, 12'd0, 32'h0);
        send(FUNC_SAMPLE, 12'hFFF, 12'hFFF, 32'h0);
        drain();
        write_reg(REG_FILTER_MODE, MODE_NEAREST);
        send(FUNC_SAMPLE, 12'hFFF, 12'd0, 32'h0);
        drain();
        write_reg(REG_SOURCE_WIDTH, 13'h1FFF);
        write_reg(REG_SOURCE_HEIGHT, 13'd0);
        write_reg(REG_TARGET_WIDTH, 13'h1FFF);
        write_reg(REG_TARGET_HEIGHT, 13'd0);
        write_reg(reg_index_t'(3'd7), 13'h1FFF);
        send(FUNC_SAMPLE, 12'd10, 12'd0, 32'h0);
        send(FUNC_SAMPLE, 12'd0, 12'd1, 32'h0);
        drain();
        write_reg(REG_FILTER_MODE, MODE_BILINEAR);
        send(FUNC_SAMPLE, 12'd4095, 12'd0, 32'h0);
        drain();
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_SOURCE_WIDTH, 13'($urandom_range(1, FILL_DIM)));
            write_reg(REG_SOURCE_HEIGHT, 13'($urandom_range(1, FILL_DIM)));
            write_reg(REG_TARGET_WIDTH, phase == 0 ? 13'd1 : 13'($urandom_range(1, 4096)));
            write_reg(REG_TARGET_HEIGHT, phase == 1 ? 13'd1 : 13'($urandom_range(1, 300)));
            write_reg(REG_FILTER_MODE, 13'(phase[0]));
            sample_random(65);
            drain();
        end
        if (fail_count == 0)
            $display("** bilinear_pixel_upscaler_unit: PASSED **");
        else
            $display("** bilinear_pixel_upscaler_unit: FAILED **");
        $finish;
    end

endmodule
